[hdl/blinn_phong_shading_top_defines.svh]
// Assertion macros for the shading pipeline
`ifndef BLINN_PHONG_SHADING_TOP_DEFINES_SVH
`define BLINN_PHONG_SHADING_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define BPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BPS_ASSERT_IMPL(name, ante, cons)
`define BPS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[hdl/bps_pkg.sv]
package bps_pkg;

    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int NIN_W      = 25;
    localparam int ABS_W      = NIN_W - 1;
    localparam int SQ_W       = 2 * ABS_W + 2;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int QUO_W      = 15;
    localparam int NORM_LAT   = 2 + SQRT_STEPS + QUO_W + 1;
    localparam int PIPE_LAT   = 2 * NORM_LAT + 11;

    localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

    localparam logic [CFG_W-1:0] RST_PLANE_NORMAL = 48'd1073741824;
    localparam logic [11:0]      RST_SHININESS    = 12'd512;
    localparam logic [15:0]      RST_LIGHT_INT    = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_NORMAL = 3'd0,
        CFG_SURFACE      = 3'd1,
        CFG_AMBIENT      = 3'd2,
        CFG_DIFFUSE      = 3'd3,
        CFG_SPECULAR     = 3'd4,
        CFG_SHININESS    = 3'd5,
        CFG_LIGHT_COLOR  = 3'd6,
        CFG_LIGHT_INT    = 3'd7
    } t_cfg_idx;

    typedef logic signed [NIN_W-1:0] t_nvec_in;
    typedef logic signed [15:0]      t_q14;

    typedef struct packed {
        logic signed [23:0] hit_x;
        logic signed [23:0] hit_y;
        logic signed [23:0] hit_z;
        logic signed [23:0] light_x;
        logic signed [23:0] light_y;
        logic signed [23:0] light_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               in_shadow;
    } t_bps_in;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } t_bps_out;

endpackage

[hdl/bps_norm.sv]
module bps_norm (
    input  logic               i_clk,
    input  bps_pkg::t_nvec_in  i_vec [3],
    output bps_pkg::t_q14      o_vec [3]
);
    import bps_pkg::*;

    typedef struct packed {
        logic [2:0][ABS_W-1:0] mag;
        logic [2:0]            neg;
    } t_mag;

    typedef struct packed {
        t_mag              m;
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqs;

    typedef struct packed {
        logic [2:0]             neg;
        logic [ROOT_W-1:0]      len;
        logic [2:0][ROOT_W-1:0] rem;
        logic [2:0][QUO_W-1:0]  quo;
        logic [2:0]             lsb;
    } t_dvs;

    t_mag              n_a_m;
    t_mag              r_a_m;
    logic [2*ABS_W-1:0] r_a_p [3];
    t_mag              r_b_m;
    logic [SQ_W-1:0]   r_b_sq;
    t_sqs              r_sq [SQRT_STEPS];
    t_dvs              r_dv [QUO_W];
    t_q14              r_out [3];

    always_comb begin
        logic [NIN_W-1:0] av;
        av = '0;
        n_a_m = '0;
        for (int k = 0; k < 3; k++) begin
            n_a_m.neg[k] = i_vec[k][NIN_W-1];
            av = n_a_m.neg[k] ? NIN_W'(-i_vec[k]) : NIN_W'(i_vec[k]);
            n_a_m.mag[k] = av[ABS_W-1:0];
        end
    end

    // squares, then their sum
    always_ff @(posedge i_clk) begin
        r_a_m <= n_a_m;
        for (int k = 0; k < 3; k++) begin
            r_a_p[k] <= (2*ABS_W)'(n_a_m.mag[k]) * (2*ABS_W)'(n_a_m.mag[k]);
        end
        r_b_m  <= r_a_m;
        r_b_sq <= SQ_W'(r_a_p[0]) + SQ_W'(r_a_p[1]) + SQ_W'(r_a_p[2]);
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        t_sqs               prv;
        t_sqs               nxt;
        logic [REM_W+1:0]   t;
        logic [REM_W+1:0]   trial;
        if (k == 0) begin : g_first
            assign prv = '{m: r_b_m, rad: r_b_sq, rem: '0, root: '0};
        end else begin : g_next
            assign prv = r_sq[k-1];
        end
        always_comb begin
            nxt   = prv;
            t     = {prv.rem, prv.rad[SQ_W-1-2*k -: 2]};
            trial = {2'b00, prv.root, 2'b01};
            if (t >= trial) begin
                nxt.rem  = REM_W'(t - trial);
                nxt.root = {prv.root[ROOT_W-2:0], 1'b1};
            end else begin
                nxt.rem  = t[REM_W-1:0];
                nxt.root = {prv.root[ROOT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq[k] <= nxt;
        end
    end

    // restoring divide of mag * 2^14 by the length, three lanes
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        t_dvs            prv;
        t_dvs            nxt;
        logic [ROOT_W:0] rem2;
        if (k == 0) begin : g_first
            always_comb begin
                prv     = '0;
                prv.neg = r_sq[SQRT_STEPS-1].m.neg;
                prv.len = r_sq[SQRT_STEPS-1].root;
                for (int c = 0; c < 3; c++) begin
                    prv.rem[c] = ROOT_W'(r_sq[SQRT_STEPS-1].m.mag[c][ABS_W-1:1]);
                    prv.lsb[c] = r_sq[SQRT_STEPS-1].m.mag[c][0];
                end
            end
        end else begin : g_next
            assign prv = r_dv[k-1];
        end
        always_comb begin
            nxt  = prv;
            rem2 = '0;
            for (int c = 0; c < 3; c++) begin
                rem2 = {prv.rem[c], (k == 0) ? prv.lsb[c] : 1'b0};
                if (rem2 >= {1'b0, prv.len}) begin
                    nxt.rem[c] = ROOT_W'(rem2 - {1'b0, prv.len});
                    nxt.quo[c] = {prv.quo[c][QUO_W-2:0], 1'b1};
                end else begin
                    nxt.rem[c] = rem2[ROOT_W-1:0];
                    nxt.quo[c] = {prv.quo[c][QUO_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv[k] <= nxt;
        end
    end

    // zero length gives the zero vector
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (r_dv[QUO_W-1].len == '0) begin
                r_out[c] <= '0;
            end else if (r_dv[QUO_W-1].neg[c]) begin
                r_out[c] <= -t_q14'({1'b0, r_dv[QUO_W-1].quo[c]});
            end else begin
                r_out[c] <= t_q14'({1'b0, r_dv[QUO_W-1].quo[c]});
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_vec[c] = r_out[c];
        end
    end

endmodule

[hdl/blinn_phong_shading_top.sv]
// Throughput: one item per cycle while busy is low; the pipeline never stalls and results cannot be held off.
// The pipeline depth is set by two chained normalizers (square, 25-step root, 15-step divide each).
// Reset: synchronous, active low; restores the register defaults and clears all valid bits.
// Busy is high only during reset and the first cycle after it.
`include "blinn_phong_shading_top_defines.svh"
module blinn_phong_shading_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  bps_pkg::t_bps_in            i_in,
    input  logic                        i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bps_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output bps_pkg::t_bps_out           o_out
);
    import bps_pkg::*;

    function automatic logic [QUO_W-1:0] f_dot_clamp(input logic signed [31:0] p0,
                                                     input logic signed [31:0] p1,
                                                     input logic signed [31:0] p2);
        logic signed [33:0] s;
        logic [19:0]        q;
        s = 34'(p0) + 34'(p1) + 34'(p2);
        q = s[33:14];
        if (s <= 0) begin
            f_dot_clamp = '0;
        end else if (q > 20'(ONE_Q14)) begin
            f_dot_clamp = ONE_Q14;
        end else begin
            f_dot_clamp = q[QUO_W-1:0];
        end
    endfunction

    logic [CFG_W-1:0] r_normal, r_surface, r_ambient, r_diffuse, r_specular, r_lcolor;
    logic [11:0]      r_shiny;
    logic [15:0]      r_lint;
    logic             r_busy;
    logic             w_accept;

    logic [23:0]      r_il [3];
    logic [39:0]      r_amb [3];
    logic [39:0]      r_kdil [3];
    logic [39:0]      r_ksil [3];

    t_q14             w_nv [3];
    t_nvec_in         r_s0_lv [3];
    t_nvec_in         r_s0_dv [3];
    logic             r_s0_v, r_s0_sh;
    t_q14             w_ln [3];
    t_q14             w_dn [3];
    t_q14             w_hn [3];

    logic [NORM_LAT-1:0] r_l1_v, r_l1_sh;
    logic             r_c_v, r_c_sh;
    t_nvec_in         r_c_hv [3];
    logic signed [31:0] r_c_p [3];
    logic             r_d_v, r_d_sh;
    logic [QUO_W-1:0] r_d_nl;
    logic [NORM_LAT-2:0] r_l2_v, r_l2_sh;
    logic [QUO_W-1:0] r_l2_nl [NORM_LAT-1];

    logic             r_e_v, r_e_sh;
    logic [QUO_W-1:0] r_e_nl;
    logic signed [31:0] r_e_p [3];
    logic             r_f_v, r_f_sh;
    logic [QUO_W-1:0] r_f_nl, r_f_nh;
    logic             r_g_v, r_g_sh, r_g_ovr;
    logic [QUO_W-1:0] r_g_nl, r_g_val;
    logic [15:0]      r_g_m;
    logic             n_g_ovr;
    logic [QUO_W-1:0] n_g_val;
    logic [15:0]      n_g_m;
    logic             r_h_v, r_h_sh, r_h_ovr;
    logic [QUO_W-1:0] r_h_nl, r_h_val;
    logic [23:0]      r_h_y;
    logic             r_i_v, r_i_sh;
    logic [QUO_W-1:0] r_i_nl, r_i_sp, n_i_sp;
    logic             r_j_v, r_k_v, r_l_v, r_m_v;
    logic [40:0]      r_j_amb [3];
    logic [40:0]      r_j_dif [3];
    logic [40:0]      r_j_spc [3];
    logic [42:0]      r_k_sum [3];
    logic [34:0]      r_l_r [3];
    t_bps_out         r_m_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal   <= RST_PLANE_NORMAL;
            r_surface  <= '0;
            r_ambient  <= '0;
            r_diffuse  <= '0;
            r_specular <= '0;
            r_shiny    <= RST_SHININESS;
            r_lcolor   <= '0;
            r_lint     <= RST_LIGHT_INT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PLANE_NORMAL: r_normal   <= i_cfg_data;
                CFG_SURFACE:      r_surface  <= i_cfg_data;
                CFG_AMBIENT:      r_ambient  <= i_cfg_data;
                CFG_DIFFUSE:      r_diffuse  <= i_cfg_data;
                CFG_SPECULAR:     r_specular <= i_cfg_data;
                CFG_SHININESS:    r_shiny    <= i_cfg_data[11:0];
                CFG_LIGHT_COLOR:  r_lcolor   <= i_cfg_data;
                CFG_LIGHT_INT:    r_lint     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy   = r_busy;
    assign w_accept = i_start & ~r_busy;

    // light-dependent factors, registered in r_il and then in r_amb, r_kdil and r_ksil
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_il[c]   <= 24'((32'(r_lint) * 32'(r_lcolor[16*c +: 16])) >> 8);
            r_amb[c]  <= 40'(r_ambient[16*c +: 16]) * 40'(r_il[c]);
            r_kdil[c] <= 40'(r_diffuse[16*c +: 16]) * 40'(r_il[c]);
            r_ksil[c] <= 40'(r_specular[16*c +: 16]) * 40'(r_il[c]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_nv[k] = t_q14'(r_normal[16*k +: 16]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_l1_v <= '0;
            r_c_v  <= 1'b0;
            r_d_v  <= 1'b0;
            r_l2_v <= '0;
            r_e_v  <= 1'b0;
            r_f_v  <= 1'b0;
            r_g_v  <= 1'b0;
            r_h_v  <= 1'b0;
            r_i_v  <= 1'b0;
            r_j_v  <= 1'b0;
            r_k_v  <= 1'b0;
            r_l_v  <= 1'b0;
            r_m_v  <= 1'b0;
        end else begin
            r_s0_v <= w_accept;
            r_l1_v <= {r_l1_v[NORM_LAT-2:0], r_s0_v};
            r_c_v  <= r_l1_v[NORM_LAT-1];
            r_d_v  <= r_c_v;
            r_l2_v <= {r_l2_v[NORM_LAT-3:0], r_d_v};
            r_e_v  <= r_l2_v[NORM_LAT-2];
            r_f_v  <= r_e_v;
            r_g_v  <= r_f_v;
            r_h_v  <= r_g_v;
            r_i_v  <= r_h_v;
            r_j_v  <= r_i_v;
            r_k_v  <= r_j_v;
            r_l_v  <= r_k_v;
            r_m_v  <= r_l_v;
        end
    end

    // light and view vectors
    always_ff @(posedge i_clk) begin
        r_s0_sh    <= i_in.in_shadow;
        r_s0_lv[0] <= NIN_W'(i_in.light_x) - NIN_W'(i_in.hit_x);
        r_s0_lv[1] <= NIN_W'(i_in.light_y) - NIN_W'(i_in.hit_y);
        r_s0_lv[2] <= NIN_W'(i_in.light_z) - NIN_W'(i_in.hit_z);
        r_s0_dv[0] <= NIN_W'(i_in.dir_x);
        r_s0_dv[1] <= NIN_W'(i_in.dir_y);
        r_s0_dv[2] <= NIN_W'(i_in.dir_z);
    end

    bps_norm u_norm_l (.i_clk(i_clk), .i_vec(r_s0_lv), .o_vec(w_ln));
    bps_norm u_norm_v (.i_clk(i_clk), .i_vec(r_s0_dv), .o_vec(w_dn));

    // half vector toward the viewer, and N.L products
    always_ff @(posedge i_clk) begin
        r_l1_sh <= {r_l1_sh[NORM_LAT-2:0], r_s0_sh};
        r_c_sh  <= r_l1_sh[NORM_LAT-1];
        for (int k = 0; k < 3; k++) begin
            r_c_hv[k] <= NIN_W'(w_ln[k]) - NIN_W'(w_dn[k]);
            r_c_p[k]  <= 32'(w_nv[k]) * 32'(w_ln[k]);
        end
        r_d_sh <= r_c_sh;
        r_d_nl <= f_dot_clamp(r_c_p[0], r_c_p[1], r_c_p[2]);
        r_l2_sh    <= {r_l2_sh[NORM_LAT-3:0], r_d_sh};
        r_l2_nl[0] <= r_d_nl;
        for (int i = 1; i < NORM_LAT - 1; i++) begin
            r_l2_nl[i] <= r_l2_nl[i-1];
        end
    end

    bps_norm u_norm_h (.i_clk(i_clk), .i_vec(r_c_hv), .o_vec(w_hn));

    // negated log2 of N.H, with the trivial exponents and bases resolved up front
    always_comb begin
        logic [3:0]  p;
        logic [13:0] rest;
        logic [25:0] f;
        p       = '0;
        rest    = '0;
        f       = '0;
        n_g_ovr = 1'b1;
        n_g_val = ONE_Q14;
        n_g_m   = '0;
        for (int b = 0; b < 14; b++) begin
            if (r_f_nh[b]) begin
                p = 4'(b);
            end
        end
        rest = r_f_nh[13:0] & ~(14'd1 << p);
        f    = {rest, 12'b0} >> p;
        n_g_m = {4'(4'd14 - p), 12'b0} - {4'b0, f[11:0]};
        if (r_shiny == '0) begin
            n_g_val = ONE_Q14;
        end else if (r_f_nh == '0) begin
            n_g_val = '0;
        end else if (r_f_nh >= ONE_Q14) begin
            n_g_val = ONE_Q14;
        end else begin
            n_g_ovr = 1'b0;
        end
    end

    // exp2 back from the scaled log
    always_comb begin
        logic [11:0] ip;
        logic [11:0] g;
        logic [4:0]  sa;
        logic [15:0] v;
        ip = r_h_y[23:12];
        g  = r_h_y[11:0];
        sa = {1'b0, ip[3:0]} + 5'd1;
        v  = (16'd32768 - {2'b00, g, 2'b00}) >> sa;
        if (r_h_ovr) begin
            n_i_sp = r_h_val;
        end else if (ip >= 12'd15) begin
            n_i_sp = '0;
        end else begin
            n_i_sp = v[QUO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_sh <= r_l2_sh[NORM_LAT-2];
        r_e_nl <= r_l2_nl[NORM_LAT-2];
        for (int k = 0; k < 3; k++) begin
            r_e_p[k] <= 32'(w_nv[k]) * 32'(w_hn[k]);
        end
        r_f_sh  <= r_e_sh;
        r_f_nl  <= r_e_nl;
        r_f_nh  <= f_dot_clamp(r_e_p[0], r_e_p[1], r_e_p[2]);
        r_g_sh  <= r_f_sh;
        r_g_nl  <= r_f_nl;
        r_g_ovr <= n_g_ovr;
        r_g_val <= n_g_val;
        r_g_m   <= n_g_m;
        r_h_sh  <= r_g_sh;
        r_h_nl  <= r_g_nl;
        r_h_ovr <= r_g_ovr;
        r_h_val <= r_g_val;
        r_h_y   <= 24'((28'(r_g_m) * 28'(r_shiny)) >> 4);
        r_i_sh  <= r_h_sh;
        r_i_nl  <= r_h_nl;
        r_i_sp  <= n_i_sp;
        for (int c = 0; c < 3; c++) begin
            // drop diffuse and specular in shadow
            r_j_amb[c] <= 41'(r_amb[c]);
            r_j_dif[c] <= r_i_sh ? '0 : 41'((55'(r_kdil[c]) * 55'(r_i_nl)) >> 14);
            r_j_spc[c] <= r_i_sh ? '0 : 41'((55'(r_ksil[c]) * 55'(r_i_sp)) >> 14);
            r_k_sum[c] <= 43'(r_j_amb[c]) + 43'(r_j_dif[c]) + 43'(r_j_spc[c]);
            r_l_r[c]   <= 35'((59'(r_surface[16*c +: 16]) * 59'(r_k_sum[c])) >> 24);
        end
        r_m_out.out_red   <= (|r_l_r[0][34:16]) ? 16'hFFFF : r_l_r[0][15:0];
        r_m_out.out_green <= (|r_l_r[1][34:16]) ? 16'hFFFF : r_l_r[1][15:0];
        r_m_out.out_blue  <= (|r_l_r[2][34:16]) ? 16'hFFFF : r_l_r[2][15:0];
    end

    assign o_strobe = r_m_v;
    assign o_out    = r_m_out;

    `BPS_ASSERT_IMPL(a_item_done, w_accept, ##PIPE_LAT o_strobe)
    `BPS_ASSERT_IMPL(a_no_orphan, o_strobe, $past(w_accept, PIPE_LAT))
    `BPS_ASSERT_IMPL(a_spec_range, r_i_v, r_i_sp <= ONE_Q14)
    `BPS_ASSERT_NEXT(a_busy_drops, o_busy, !o_busy)

endmodule
